FILE: src/utf8_to_iso8859_decoder_top_assert.svh
// Assertion macros for the UTF-8 to ISO-8859 decoder.
// Needs clk_i and rst_ni in the scope of use; empty under SYNTHESIS.
`ifndef UTF8_TO_ISO8859_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_ISO8859_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define U2I_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds during reset.
`define U2I_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define U2I_ASSERT(lbl, prop, msg)
`define U2I_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: src/u2i_pkg.sv
// Types and constants of the UTF-8 to ISO-8859 decoder.
// No dependencies; used by every module of the block.
package u2i_pkg;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  // Result transfer payload.
  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic [2:0] charset;
    logic       text_done;
  } out_item_t;

  // Core state visible to the top level.
  typedef struct packed {
    logic [1:0] pending;
    logic [2:0] charset;
  } status_t;

  // Lead byte thresholds.
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;

  // Pending continuation counts.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Charset codes.
  localparam logic [2:0] CS_UNKNOWN = 3'd0;
  localparam logic [2:0] CS_8859_1  = 3'd1;
  localparam logic [2:0] CS_8859_2  = 3'd2;
  localparam logic [2:0] CS_8859_7  = 3'd3;
  localparam logic [2:0] CS_8859_5  = 3'd4;
  localparam logic [2:0] CS_8859_8  = 3'd5;
  localparam logic [2:0] CS_8859_6  = 3'd6;

  // Code pages (high byte of a decoded code).
  localparam logic [7:0] PAGE_LATIN1   = 8'h00;
  localparam logic [7:0] PAGE_LATIN2   = 8'h01;
  localparam logic [7:0] PAGE_GREEK    = 8'h03;
  localparam logic [7:0] PAGE_CYRILLIC = 8'h04;
  localparam logic [7:0] PAGE_HEBREW   = 8'h05;
  localparam logic [7:0] PAGE_ARABIC   = 8'h06;

  // Page offsets added to the low byte.
  localparam logic [7:0] OFS_GREEK    = 8'h30;
  localparam logic [7:0] OFS_CYRILLIC = 8'hA0;
  localparam logic [7:0] OFS_HEBREW   = 8'h10;
  localparam logic [7:0] OFS_NONE     = 8'h00;

  function automatic logic [7:0] page_offset(input logic [7:0] high);
    logic [7:0] ofs;
    case (high)
      PAGE_GREEK:    ofs = OFS_GREEK;
      PAGE_CYRILLIC: ofs = OFS_CYRILLIC;
      PAGE_HEBREW:   ofs = OFS_HEBREW;
      default:       ofs = OFS_NONE;
    endcase
    return ofs;
  endfunction

  function automatic logic [2:0] charset_from_page(input logic [7:0] high,
                                                   input logic [2:0] current);
    logic [2:0] cs;
    case (high)
      PAGE_LATIN1:   cs = CS_8859_1;
      PAGE_LATIN2:   cs = CS_8859_2;
      PAGE_GREEK:    cs = CS_8859_7;
      PAGE_CYRILLIC: cs = CS_8859_5;
      PAGE_HEBREW:   cs = CS_8859_8;
      PAGE_ARABIC:   cs = CS_8859_6;
      default:       cs = current;
    endcase
    return cs;
  endfunction

endpackage

FILE: src/u2i_in_reg.sv
// Input register of the UTF-8 to ISO-8859 decoder.
// Depends on u2i_pkg.
module u2i_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              drain_i,
  input  u2i_pkg::in_item_t item_i,
  output logic              valid_o,
  output u2i_pkg::in_item_t item_o
);

  logic              valid_d, valid_q;
  u2i_pkg::in_item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/u2i_core.sv
// Decode state and per-byte logic of the UTF-8 to ISO-8859 decoder.
// Depends on u2i_pkg.
module u2i_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  u2i_pkg::in_item_t  item_i,
  output u2i_pkg::out_item_t res_o,
  output u2i_pkg::status_t   status_o
);

  logic [1:0]  pending_d, pending_q;
  logic [15:0] acc_d, acc_q;
  logic [2:0]  charset_d, charset_q;

  logic [15:0] acc_shift;
  logic [1:0]  pend_dec;
  logic [7:0]  high, low;
  logic [7:0]  b;

  assign b         = item_i.in_byte;
  assign acc_shift = {acc_q[9:0], b[5:0]};
  assign pend_dec  = pending_q - 2'd1;
  assign high      = acc_shift[15:8];
  assign low       = acc_shift[7:0];

  always_comb begin
    pending_d       = pending_q;
    acc_d           = acc_q;
    charset_d       = charset_q;
    res_o.char_valid = 1'b0;
    res_o.out_char   = 8'h00;
    if (pending_q != u2i_pkg::PEND_NONE) begin
      // continuation, whatever the byte value
      pending_d = pend_dec;
      acc_d     = acc_shift;
      if (pend_dec == u2i_pkg::PEND_NONE) begin
        if (charset_q == u2i_pkg::CS_UNKNOWN || charset_q == u2i_pkg::CS_8859_1) begin
          charset_d = u2i_pkg::charset_from_page(high, charset_q);
        end
        res_o.char_valid = 1'b1;
        res_o.out_char   = low + u2i_pkg::page_offset(high);
        acc_d            = 16'h0000;
      end
    end else if (b >= u2i_pkg::LEAD3_MIN) begin
      acc_d     = {12'h000, b[3:0]};
      pending_d = u2i_pkg::PEND_TWO;
    end else if (b >= u2i_pkg::LEAD2_MIN) begin
      acc_d     = {11'h000, b[4:0]};
      pending_d = u2i_pkg::PEND_ONE;
    end else begin
      res_o.char_valid = 1'b1;
      res_o.out_char   = b;
    end
    res_o.charset   = charset_d;
    res_o.text_done = item_i.end_of_text;
  end

  // end of text: discard any open sequence and forget the charset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= u2i_pkg::PEND_NONE;
      acc_q     <= 16'h0000;
      charset_q <= u2i_pkg::CS_UNKNOWN;
    end else if (fire_i) begin
      if (item_i.end_of_text) begin
        pending_q <= u2i_pkg::PEND_NONE;
        acc_q     <= 16'h0000;
        charset_q <= u2i_pkg::CS_UNKNOWN;
      end else begin
        pending_q <= pending_d;
        acc_q     <= acc_d;
        charset_q <= charset_d;
      end
    end
  end

  assign status_o.pending = pending_q;
  assign status_o.charset = charset_q;

endmodule

FILE: src/u2i_out_reg.sv
// Result register of the UTF-8 to ISO-8859 decoder.
// Depends on u2i_pkg.
module u2i_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               stall_i,
  input  u2i_pkg::out_item_t item_i,
  output logic               valid_o,
  output u2i_pkg::out_item_t item_o
);

  logic               valid_d, valid_q;
  u2i_pkg::out_item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/utf8_to_iso8859_decoder_top.sv
// UTF-8 to ISO-8859 decoder, one byte per transfer, one result per byte.
// Each byte is held in the input register, decoded, and its result is held in the
// result register until the result transfer.
// Throughput: 1 byte per cycle unless the result channel stalls; the decode state is updated as each byte is decoded.
// Reset (rst_ni low, async): both stages empty, no bytes pending, charset unknown.
// Depends on u2i_pkg, u2i_in_reg, u2i_core, u2i_out_reg and the assert header.
`include "utf8_to_iso8859_decoder_top_assert.svh"

module utf8_to_iso8859_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  u2i_pkg::in_item_t  in_item_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output u2i_pkg::out_item_t out_item_o
);

  // Pipeline:
  //   in_reg  -> holds the accepted byte
  //   core    -> decode state (pending count, accumulator, charset) and the
  //              combinational decode of the held byte
  //   out_reg -> holds the result until the sink takes it
  // The held byte is decoded ("fires") when the result register is free or is
  // being emptied this cycle; the state is updated on that same edge, so the
  // next byte in the input register always sees up-to-date state.

  logic               in_q_valid;
  u2i_pkg::in_item_t  in_q_item;
  u2i_pkg::out_item_t core_res;
  u2i_pkg::status_t   core_status;
  logic               advance;
  logic               fire;
  logic               in_take;

  assign advance    = !out_valid_o || !out_stall_i;
  assign fire       = in_q_valid && advance;
  // input register can take a byte when empty or when its byte moves on
  assign in_stall_o = in_q_valid && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  u2i_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_take),
    .drain_i (fire),
    .item_i  (in_item_i),
    .valid_o (in_q_valid),
    .item_o  (in_q_item)
  );

  u2i_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_q_item),
    .res_o    (core_res),
    .status_o (core_status)
  );

  u2i_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .stall_i (out_stall_i),
    .item_i  (core_res),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a result without a character carries a zero character
  `U2I_ASSERT(a_no_char_zero, out_valid_o && !out_item_o.char_valid |-> out_item_o.out_char == 8'h00, "char without char_valid")

  // end of text leaves clean state behind
  `U2I_ASSERT(a_eot_clears, fire && in_q_item.end_of_text |=> core_status.pending == u2i_pkg::PEND_NONE && core_status.charset == u2i_pkg::CS_UNKNOWN, "state not cleared after end of text")

  // charset only moves when a byte is decoded
  `U2I_ASSERT(a_charset_hold, !fire |=> $stable(core_status.charset), "charset changed without a decode")

  // a lead byte with nothing pending gives no character
  `U2I_ASSERT(a_lead_no_char, fire && core_status.pending == u2i_pkg::PEND_NONE && in_q_item.in_byte >= u2i_pkg::LEAD2_MIN |=> !out_item_o.char_valid, "lead byte produced a character")

  // pending count never exceeds a three-byte sequence; vacuous while in reset
  `U2I_ASSERT_ALWAYS(a_pending_range, !rst_ni || core_status.pending != 2'd3, "pending count out of range")

endmodule

FILE: verif/u2i_decode_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 to ISO-8859 decoder. It watches both channels,
// predicts each result from the accepted bytes and compares. Needs u2i_pkg.
module u2i_decode_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  u2i_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  u2i_pkg::out_item_t out_item_i,
  output int                 mismatch_count_o,
  output int                 awaited_count_o,
  output int                 checked_count_o
);

  // Decoder state as this checker sees it.
  logic [1:0]         conts_left;
  logic [15:0]        code_acc;
  logic [2:0]         text_charset;
  u2i_pkg::out_item_t awaited_chars[$];
  int                 mismatches;
  int                 checked;

  // Advance the decoder state by one byte and return the result it gives.
  function automatic u2i_pkg::out_item_t decode_byte(input u2i_pkg::in_item_t item);
    u2i_pkg::out_item_t res;
    logic [7:0]         page;
    logic [7:0]         ofs;
    res = '0;
    if (conts_left != u2i_pkg::PEND_NONE) begin
      code_acc   = {code_acc[9:0], item.in_byte[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left == u2i_pkg::PEND_NONE) begin
        page = code_acc[15:8];
        case (page)
          u2i_pkg::PAGE_GREEK:    ofs = u2i_pkg::OFS_GREEK;
          u2i_pkg::PAGE_CYRILLIC: ofs = u2i_pkg::OFS_CYRILLIC;
          u2i_pkg::PAGE_HEBREW:   ofs = u2i_pkg::OFS_HEBREW;
          default:                ofs = u2i_pkg::OFS_NONE;
        endcase
        // detection only moves away from unknown or Latin-1
        if (text_charset == u2i_pkg::CS_UNKNOWN || text_charset == u2i_pkg::CS_8859_1) begin
          case (page)
            u2i_pkg::PAGE_LATIN1:   text_charset = u2i_pkg::CS_8859_1;
            u2i_pkg::PAGE_LATIN2:   text_charset = u2i_pkg::CS_8859_2;
            u2i_pkg::PAGE_GREEK:    text_charset = u2i_pkg::CS_8859_7;
            u2i_pkg::PAGE_CYRILLIC: text_charset = u2i_pkg::CS_8859_5;
            u2i_pkg::PAGE_HEBREW:   text_charset = u2i_pkg::CS_8859_8;
            u2i_pkg::PAGE_ARABIC:   text_charset = u2i_pkg::CS_8859_6;
            default:                text_charset = text_charset;
          endcase
        end
        res.char_valid = 1'b1;
        res.out_char   = code_acc[7:0] + ofs;
        code_acc       = '0;
      end
    end else if (item.in_byte >= u2i_pkg::LEAD3_MIN) begin
      code_acc   = {12'd0, item.in_byte[3:0]};
      conts_left = u2i_pkg::PEND_TWO;
    end else if (item.in_byte >= u2i_pkg::LEAD2_MIN) begin
      code_acc   = {11'd0, item.in_byte[4:0]};
      conts_left = u2i_pkg::PEND_ONE;
    end else begin
      res.char_valid = 1'b1;
      res.out_char   = item.in_byte;
    end
    res.charset   = text_charset;
    res.text_done = item.end_of_text;
    if (item.end_of_text) begin
      conts_left   = u2i_pkg::PEND_NONE;
      code_acc     = '0;
      text_charset = u2i_pkg::CS_UNKNOWN;
    end
    return res;
  endfunction

  function automatic int field_differs(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    u2i_pkg::out_item_t want;
    if (!rst_ni) begin
      conts_left   = u2i_pkg::PEND_NONE;
      code_acc     = '0;
      text_charset = u2i_pkg::CS_UNKNOWN;
      mismatches   = 0;
      checked      = 0;
      awaited_chars.delete();
      mismatch_count_o <= 0;
      awaited_count_o  <= 0;
      checked_count_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_chars.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_item_i);
          mismatches++;
        end else begin
          want = awaited_chars.pop_front();
          checked++;
          mismatches += field_differs("char_valid", 8'(want.char_valid),
                                      8'(out_item_i.char_valid))
                      + field_differs("out_char", want.out_char, out_item_i.out_char)
                      + field_differs("charset", 8'(want.charset), 8'(out_item_i.charset))
                      + field_differs("text_done", 8'(want.text_done),
                                      8'(out_item_i.text_done));
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_chars.push_back(decode_byte(in_item_i));
      mismatch_count_o <= mismatches;
      awaited_count_o  <= awaited_chars.size();
      checked_count_o  <= checked;
    end
  end

endmodule

FILE: verif/utf8_to_iso8859_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for utf8_to_iso8859_decoder_top: drives UTF-8 byte streams and
// gives the verdict. Depends on u2i_pkg, the block's RTL and u2i_decode_checker.
module utf8_to_iso8859_decoder_top_tb;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  u2i_pkg::in_item_t  in_item_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  u2i_pkg::out_item_t out_item_o;

  int mismatch_count;
  int awaited_count;
  int checked_count;

  // Sender bookkeeping: transfers left in the current burst, totals.
  int burst_left  = 0;
  int bytes_sent  = 0;
  int texts_ended = 0;

  // Receiver stall pattern: a new mode each time stall_tick wraps to zero.
  int         stall_tick = 0;
  logic [1:0] stall_mode = 2'd0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  utf8_to_iso8859_decoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  u2i_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_i       (out_item_o),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count),
    .checked_count_o  (checked_count)
  );

  // Result side back-pressure. Modes: never stall, light random, a fixed
  // on-off rhythm from stall_tick, heavy random. The free-running rhythm drifts
  // against the sender's bursts so stalls land on every pipeline phase.
  always @(posedge clk_i) begin
    if (stall_tick == 0)
      stall_mode = 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall_i <= ((stall_tick % 4) >= 2);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
    stall_tick = (stall_tick + 1) % 48;
  end

  // One byte transfer. Bursts of random length; between bursts valid may
  // drop for a random gap. Valid is only lowered when a real gap follows,
  // so it never gets two updates in one step.
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{in_byte: value, end_of_text: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
    if (last)
      texts_ended++;
  endtask

  // Hold the sender off until every predicted result has been seen.
  // The checker's count is registered, hence the first wait.
  task automatic drain_results(input int max_cycles);
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (awaited_count != 0 && waited < max_cycles) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Directed opening: {byte, end_of_text}.
  //   plain bytes incl. 0x00 / 0x7F, a stray continuation,
  //   Latin-1 then Greek (detection moves on from 8859-1),
  //   Cyrillic while Greek is locked in (no update, offset still applied),
  //   end of text on a plain byte,
  //   a lead byte where a continuation belongs,
  //   0xF0 and 0xFF taken as three-byte leads,
  //   a sequence still open at end of text,
  //   Hebrew, Arabic and Latin-2 texts, end of text on a lead byte.
  logic [8:0] opening[] = '{
    {8'h41, 1'b0}, {8'h7F, 1'b0}, {8'h80, 1'b0},
    {8'hC3, 1'b0}, {8'hA9, 1'b0}, {8'hCE, 1'b0}, {8'hB1, 1'b0},
    {8'hD0, 1'b0}, {8'h90, 1'b0}, {8'h00, 1'b1},
    {8'hE0, 1'b0}, {8'hC0, 1'b0}, {8'hBF, 1'b0},
    {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'hBF, 1'b0},
    {8'hFF, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0},
    {8'hEF, 1'b0}, {8'hBF, 1'b1},
    {8'hD7, 1'b0}, {8'h90, 1'b1}, {8'hD8, 1'b0}, {8'hA7, 1'b1},
    {8'hC5, 1'b0}, {8'h81, 1'b0}, {8'hC2, 1'b1}
  };

  initial begin
    logic [7:0] seq[$];
    int         kind;
    int         random_bytes;
    bit         paused;

    random_bytes = 0;
    paused       = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i])
      send_byte(opening[i][8:1], opening[i][0]);

    // Pressure point: let the pipeline run dry before the random part.
    drain_results(5000);

    // Random part: mostly well-formed characters with random content,
    // some stray continuations, broken sequences and raw noise.
    // End of text falls on any byte about one time in 24.
    while (random_bytes < 700) begin
      seq.delete();
      kind = $urandom_range(0, 19);
      if (kind <= 3) begin
        seq.push_back(8'($urandom_range(8'h00, 8'h7F)));
      end else if (kind == 4) begin
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind <= 9) begin
        // two-byte: lead bits 4:2 pick pages 0..7
        seq.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind <= 15) begin
        // three-byte: half of them on lead 0xE0 so low pages show up too
        if ($urandom_range(0, 1) == 0)
          seq.push_back(8'hE0);
        else
          seq.push_back(8'($urandom_range(8'hE0, 8'hFF)));
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
        seq.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind <= 17) begin
        // broken: lead followed by anything
        seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
        seq.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0)
          seq.push_back(8'($urandom));
      end else begin
        seq.push_back(8'($urandom));
      end
      foreach (seq[i])
        send_byte(seq[i], ($urandom_range(0, 23) == 0));
      random_bytes += seq.size();
      if (!paused && random_bytes >= 350) begin
        drain_results(5000);
        paused = 1'b1;
      end
    end

    // Wind down: wait for the backlog, then keep the clock running so a stray
    // extra result would still be caught.
    drain_results(5000);
    repeat (10) @(posedge clk_i);

    if (awaited_count != 0)
      $display("%0t: %0d results never arrived", $time, awaited_count);
    $display("Sent %0d bytes (%0d closed texts), %0d results compared.",
             bytes_sent, texts_ended, checked_count);
    $display("Mix: ASCII, stray and misplaced bytes, 2/3-byte codes over all pages.");
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
